[design/bsd_pkg.sv]
// Shared types, constants and helpers for the 3-D box-sum downsampler.
package bsd_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_SCALE  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int SUM_W       = 44;
    localparam int DEPTH_LIMIT = 64;
    localparam int DEP_W       = 6;
    localparam int SCALE_W     = 5;
    localparam int SIZE_W      = 7;
    localparam int LIM_W       = 11;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DEPTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_PLANE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_DEPTH  = 3'd4;

    typedef struct packed {
        logic [SCALE_W-1:0] scale_depth;
        logic [SCALE_W-1:0] scale_plane;
        logic [SIZE_W-1:0]  small_width;
        logic [SIZE_W-1:0]  small_height;
        logic [SIZE_W-1:0]  small_depth;
    } t_cfg;

    typedef struct packed {
        logic first;
        logic last;
        logic vend;
    } t_pos_flags;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic                    vend;
    } t_res;

    function automatic logic [LIM_W-1:0] f_clamp(input logic [SIZE_W-1:0] v,
                                                 input logic [LIM_W-1:0] hi);
        logic [LIM_W-1:0] v_ext;
        v_ext = LIM_W'(v);
        if (v == '0) begin
            return LIM_W'(1);
        end else if (v_ext > hi) begin
            return hi;
        end
        return v_ext;
    endfunction

endpackage

[design/bsd_pos.sv]
// Position counters: box sub-offsets, box indices, store address and box flags.
module bsd_pos
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE,
    parameter int ADDR_W     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_cfg              i_cfg,
    output logic [ADDR_W-1:0] o_addr,
    output t_pos_flags        o_flags
);

    localparam int SUB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [SUB_W:0] lim_sd, lim_sp;
    logic [COL_W:0] lim_w;
    logic [ROW_W:0] lim_h;
    logic [DEP_W:0] lim_d;

    logic [SUB_W-1:0] r_sub_col, n_sub_col, r_sub_row, n_sub_row, r_sub_depth, n_sub_depth;
    logic [COL_W-1:0] r_block_col, n_block_col;
    logic [ROW_W-1:0] r_block_row, n_block_row;
    logic [DEP_W-1:0] r_block_depth, n_block_depth;

    logic w_sc, w_bc, w_sr, w_br, w_sd, w_bd;

    assign lim_sd = (SUB_W+1)'(f_clamp(SIZE_W'(i_cfg.scale_depth), LIM_W'(MAX_SCALE)));
    assign lim_sp = (SUB_W+1)'(f_clamp(SIZE_W'(i_cfg.scale_plane), LIM_W'(MAX_SCALE)));
    assign lim_w  = (COL_W+1)'(f_clamp(i_cfg.small_width, LIM_W'(MAX_WIDTH)));
    assign lim_h  = (ROW_W+1)'(f_clamp(i_cfg.small_height, LIM_W'(MAX_HEIGHT)));
    assign lim_d  = (DEP_W+1)'(f_clamp(i_cfg.small_depth, LIM_W'(DEPTH_LIMIT)));

    assign w_sc = ({1'b0, r_sub_col} + 1'b1) >= lim_sp;
    assign w_bc = ({1'b0, r_block_col} + 1'b1) >= lim_w;
    assign w_sr = ({1'b0, r_sub_row} + 1'b1) >= lim_sp;
    assign w_br = ({1'b0, r_block_row} + 1'b1) >= lim_h;
    assign w_sd = ({1'b0, r_sub_depth} + 1'b1) >= lim_sd;
    assign w_bd = ({1'b0, r_block_depth} + 1'b1) >= lim_d;

    always_comb begin
        n_sub_col     = w_sc ? '0 : r_sub_col + 1'b1;
        n_block_col   = r_block_col;
        n_sub_row     = r_sub_row;
        n_block_row   = r_block_row;
        n_sub_depth   = r_sub_depth;
        n_block_depth = r_block_depth;
        if (w_sc) begin
            n_block_col = w_bc ? '0 : r_block_col + 1'b1;
            if (w_bc) begin
                n_sub_row = w_sr ? '0 : r_sub_row + 1'b1;
                if (w_sr) begin
                    n_block_row = w_br ? '0 : r_block_row + 1'b1;
                    if (w_br) begin
                        n_sub_depth = w_sd ? '0 : r_sub_depth + 1'b1;
                        if (w_sd) begin
                            n_block_depth = w_bd ? '0 : r_block_depth + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col     <= '0;
            r_block_col   <= '0;
            r_sub_row     <= '0;
            r_block_row   <= '0;
            r_sub_depth   <= '0;
            r_block_depth <= '0;
        end else if (i_adv) begin
            r_sub_col     <= n_sub_col;
            r_block_col   <= n_block_col;
            r_sub_row     <= n_sub_row;
            r_block_row   <= n_block_row;
            r_sub_depth   <= n_sub_depth;
            r_block_depth <= n_block_depth;
        end
    end

    assign o_addr = ADDR_W'(r_block_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_block_col);

    assign o_flags.first = (r_sub_col == '0) && (r_sub_row == '0) && (r_sub_depth == '0);
    assign o_flags.last  = w_sc && w_sr && w_sd;
    assign o_flags.vend  = w_bc && w_br && w_bd;

endmodule

[design/bsd_acc.sv]
// Partial-sum store with read-modify-write stage and write-to-read bypass.
module bsd_acc
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ADDR_W     = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [ADDR_W-1:0]            i_addr,
    input  t_pos_flags                   i_flags,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_out_free,
    output logic                         o_take,
    output t_res                         o_res
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic signed [SUM_W-1:0] mem [DEPTH];

    logic                    r_s1_valid;
    logic [ADDR_W-1:0]       r_s1_addr;
    t_pos_flags              r_s1_flags;
    logic signed [SUM_W-1:0] r_s1_val;
    logic                    r_fwd;
    logic signed [SUM_W-1:0] r_fwd_sum;
    logic signed [SUM_W-1:0] r_rd;

    logic signed [SUM_W-1:0] val_ext, old_sum, sum;
    logic                    leave;

    assign val_ext = SUM_W'(i_value);
    assign old_sum = r_fwd ? r_fwd_sum : r_rd;
    assign sum     = r_s1_flags.first ? r_s1_val : old_sum + r_s1_val;
    assign leave   = r_s1_valid && (!r_s1_flags.last || i_out_free);
    assign o_take  = !r_s1_valid || leave;

    assign o_res.valid = leave && r_s1_flags.last;
    assign o_res.sum   = sum;
    assign o_res.vend  = r_s1_flags.vend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (leave) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_addr  <= i_addr;
            r_s1_flags <= i_flags;
            r_s1_val   <= val_ext;
            r_fwd      <= leave && (r_s1_addr == i_addr);
            r_fwd_sum  <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            mem[r_s1_addr] <= sum;
        end
        if (i_accept) begin
            r_rd <= mem[i_addr];
        end
    end

endmodule

[design/box_sum_downsample_3d.sv]
// Top level of the 3-D box-sum downsampler: configuration, handshakes, result register.
// A box sum passes the read-modify-write stage, then the result register, to o_valid.
// Throughput: one element per cycle unless a finished box waits on a stalled output;
// each is a read-add-write of the partial-sum store, bypassed for back-to-back same-entry hits.
// Reset: counters and valids clear, registers return to scale 1/1 and size 64/64/64;
// the partial-sum store is not cleared, since each box's first element overwrites it.
module box_sum_downsample_3d
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_grad_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SUM_W-1:0]      o_grad_sum,
    output logic                         o_volume_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [SIZE_W-1:0]            i_cfg_data
);

    localparam int ADDR_W = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

    t_cfg                    r_cfg;
    logic                    r_o_valid;
    logic signed [SUM_W-1:0] r_o_sum;
    logic                    r_o_vend;

    logic              accept, take, out_free;
    logic [ADDR_W-1:0] addr;
    t_pos_flags        flags;
    t_res              res;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_o_valid || !i_stall;
    assign accept      = i_valid && take;
    assign o_stall     = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_depth  <= SCALE_W'(1);
            r_cfg.scale_plane  <= SCALE_W'(1);
            r_cfg.small_width  <= SIZE_W'(64);
            r_cfg.small_height <= SIZE_W'(64);
            r_cfg.small_depth  <= SIZE_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCALE_DEPTH: begin
                    r_cfg.scale_depth <= i_cfg_data[SCALE_W-1:0];
                end
                CFG_SCALE_PLANE: begin
                    r_cfg.scale_plane <= i_cfg_data[SCALE_W-1:0];
                end
                CFG_SMALL_WIDTH: begin
                    r_cfg.small_width <= i_cfg_data;
                end
                CFG_SMALL_HEIGHT: begin
                    r_cfg.small_height <= i_cfg_data;
                end
                CFG_SMALL_DEPTH: begin
                    r_cfg.small_depth <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    bsd_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_SCALE (MAX_SCALE),
        .ADDR_W    (ADDR_W)
    ) u_pos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (accept),
        .i_cfg  (r_cfg),
        .o_addr (addr),
        .o_flags(flags)
    );

    bsd_acc #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .DATA_WIDTH(DATA_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_addr    (addr),
        .i_flags   (flags),
        .i_value   (i_grad_value),
        .i_out_free(out_free),
        .o_take    (take),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res.valid) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_o_sum  <= res.sum;
            r_o_vend <= res.vend;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_grad_sum   = r_o_sum;
    assign o_volume_end = r_o_vend;

endmodule

[design/bsd_checker.sv]
// Port-level checker for the 3-D box-sum downsampler and its bind.
module bsd_checker
    import bsd_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [SUM_W-1:0] o_grad_sum,
    input logic                    o_volume_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grad_sum) && $stable(o_volume_end))
        else $error("stalled result changed or dropped");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side drains");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty result register");

    a_reset_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind box_sum_downsample_3d bsd_checker u_bsd_checker (.*);
